FILE: hdl/tftp_pkg.sv
// tunnel frame tlv parser package: phases, byte tags, message constants
// no dependencies
`timescale 1ns / 1ps

package tftp_pkg;

    typedef enum logic [3:0] {
        PH_START, PH_SHIM, PH_HDR, PH_UC, PH_BC, PH_PAYLOAD, PH_CTRL, PH_EXTRA,
        PH_TLV_TYPE, PH_TLV_LEN, PH_TLV_LEN2, PH_VALUE, PH_1E, PH_UNKNOWN, PH_TRAIL
    } t_phase;

    localparam logic [4:0] TAG_SHIM_UNK = 5'd0;
    localparam logic [4:0] TAG_SHIM_LEN = 5'd1;
    localparam logic [4:0] TAG_HDR_UNK  = 5'd2;
    localparam logic [4:0] TAG_DSTID    = 5'd3;
    localparam logic [4:0] TAG_SRCID    = 5'd4;
    localparam logic [4:0] TAG_DSTTYPE  = 5'd5;
    localparam logic [4:0] TAG_SRCTYPE  = 5'd6;
    localparam logic [4:0] TAG_DATA_UNK = 5'd7;
    localparam logic [4:0] TAG_VLAN     = 5'd8;
    localparam logic [4:0] TAG_SEQNO    = 5'd9;
    localparam logic [4:0] TAG_PAYLOAD  = 5'd10;
    localparam logic [4:0] TAG_ZERO     = 5'd11;
    localparam logic [4:0] TAG_CTRL_UNK = 5'd12;
    localparam logic [4:0] TAG_1E_UNK   = 5'd13;
    localparam logic [4:0] TAG_PRE      = 5'd14;
    localparam logic [4:0] TAG_HDRLEN   = 5'd15;
    localparam logic [4:0] TAG_MSGTYPE  = 5'd16;
    localparam logic [4:0] TAG_SENDER   = 5'd17;
    localparam logic [4:0] TAG_EXTRA    = 5'd18;
    localparam logic [4:0] TAG_MSG22    = 5'd19;
    localparam logic [4:0] TAG_TLV_TYPE = 5'd20;
    localparam logic [4:0] TAG_ARRAY    = 5'd21;
    localparam logic [4:0] TAG_TLV_LEN  = 5'd22;
    localparam logic [4:0] TAG_VALUE    = 5'd23;
    localparam logic [4:0] TAG_ELEMENT  = 5'd24;
    localparam logic [4:0] TAG_TRAIL    = 5'd25;

    localparam logic [1:0] SRC_DATA = 2'd1;
    localparam logic [1:0] SRC_SHIM = 2'd2;

    localparam logic [15:0] TYPE_UC   = 16'h0001;
    localparam logic [15:0] TYPE_BC   = 16'h0002;
    localparam logic [15:0] TYPE_C0C  = 16'h000c;
    localparam logic [15:0] TYPE_C1E  = 16'h001e;
    localparam logic [15:0] TYPE_T22  = 16'h0022;

    localparam logic [31:0] MSG_CSNP = 32'h43534E50;
    localparam logic [31:0] MSG_LSP  = 32'h4C535000;
    localparam logic [31:0] MSG_PSNP = 32'h50534E50;

    localparam logic [7:0] TLV_ARRAY_KIND = 8'h01;
    localparam logic [7:0] ARRAY_MARK     = 8'd128;

    typedef struct packed {
        logic [4:0]  tag;
        logic [15:0] frame_type;
        logic        el_start;
        logic        truncated;
        logic        frame_end;
    } t_result;

    // length rounded up to whole elements of 4, 8 or 12 bytes; other sizes pass it through
    function automatic logic [8:0] round_elem(input logic [7:0] d, input logic [3:0] sz);
        logic [8:0]  q3;
        logic [8:0]  t;
        logic [16:0] prod;
        q3   = 9'd0;
        t    = 9'd0;
        prod = 17'd0;
        unique case (sz)
            4'd4:  round_elem = {1'b0, d} + 9'd3 & 9'h1fc;
            4'd8:  round_elem = {1'b0, d} + 9'd7 & 9'h1f8;
            4'd12: begin
                t = {1'b0, d} + 9'd11;
                // t/12 = (t>>2)/3 ; t>>2 < 67
                prod = {10'd0, t[8:2]} * 17'd171;
                q3 = {2'b0, prod[15:9]};
                round_elem = 9'(q3 * 9'd12);
            end
            default: round_elem = {1'b0, d};
        endcase
    endfunction

endpackage

FILE: hdl/tunnel_frame_tlv_parser.sv
// tunnel frame tlv parser top level: handshake, parse core, output register
// depends on tftp_pkg and tftp_core
`timescale 1ns / 1ps
//
// usage: one frame byte per slave beat, one tagged result per master beat.
// slave tdata: data_byte[7:0], frame_length[23:8], source[25:24]; tlast: last_byte.
// master tdata: byte_tag[4:0], frame_type[20:5], element_start[21],
//   truncated[22]; tlast: frame_end.
// the parse state updates in the accept cycle; the result lands in a single
// output register in the cycle after the accept, and a beat is taken every cycle unless the receiver stalls.
// when the receiver stalls, the output register holds and the slave side
// still accepts while the register is empty or draining in the same cycle.
// reset clears the parse state to frame start and empties the output.
// source and frame_length are sampled on the first byte of each frame.
// a byte with tlast set closes the frame; the next byte opens a new one.
//

module tunnel_frame_tlv_parser import tftp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // data_byte, frame_length, source
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // byte_tag, frame_type, element_start, truncated
    output logic        m_axis_tlast
);

    logic    acc;
    t_result res;
    t_result r_out;
    logic    r_vld;

    assign s_axis_tready = !r_vld || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;

    tftp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (acc),
        .i_data         (s_axis_tdata[7:0]),
        .i_frame_length (s_axis_tdata[23:8]),
        .i_source       (s_axis_tdata[25:24]),
        .i_last         (s_axis_tlast),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_out <= res;
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata = {1'b0, r_out.truncated, r_out.el_start, r_out.frame_type, r_out.tag};
    assign m_axis_tlast = r_out.frame_end;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[4:0] == TAG_ELEMENT)
        else $error("element start on non element byte");
    a_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= TAG_TRAIL)
        else $error("tag out of range");
`endif

endmodule

FILE: hdl/tftp_core.sv
// per-byte parse state and tag decision of the tunnel frame parser
// depends on tftp_pkg
`timescale 1ns / 1ps

module tftp_core import tftp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_frame_length,
    input  logic [1:0]  i_source,
    input  logic        i_last,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [16:0] r_len, n_len;
    logic [15:0] r_type, n_type;
    logic [7:0]  r_thigh, n_thigh;
    logic [7:0]  r_hext, n_hext;
    logic [31:0] r_msg, n_msg;
    logic [3:0]  r_esz, n_esz;
    logic [7:0]  r_kind, n_kind;
    logic [8:0]  r_rem, n_rem;
    logic [3:0]  r_ecnt, n_ecnt;
    logic        r_stop, n_stop;
    logic [1:0]  r_via, n_via;

    t_phase      ph;
    logic [15:0] r;
    logic [16:0] pos17;
    logic        split;
    logic [7:0]  dlen;
    logic        do_take;
    logic [4:0]  tag;
    logic        el;

    always_comb begin
        n_pos = r_pos; n_len = r_len; n_type = r_type; n_thigh = r_thigh;
        n_hext = r_hext; n_msg = r_msg; n_esz = r_esz; n_kind = r_kind;
        n_rem = r_rem; n_ecnt = r_ecnt; n_stop = r_stop; n_via = r_via;
        ph = r_phase;
        if (r_phase == PH_START) begin
            n_pos = '0; n_type = '0; n_thigh = '0; n_hext = '0; n_msg = '0;
            n_esz = '0; n_kind = '0; n_rem = '0; n_ecnt = '0; n_stop = 1'b0;
            n_via = i_source;
            n_len = {1'b0, i_frame_length};
            ph = (i_source == SRC_SHIM) ? PH_SHIM : PH_HDR;
        end
        n_phase = ph;
        r = n_pos - ((n_via == SRC_SHIM) ? 16'd4 : 16'd0);
        pos17 = {1'b0, n_pos};
        split = (n_kind == TLV_ARRAY_KIND) && (n_esz != 4'd0);
        tag = TAG_TRAIL;
        el = 1'b0;
        do_take = 1'b0;
        dlen = i_data;
        unique case (ph)
            PH_SHIM: begin
                tag = (n_pos < 16'd2) ? TAG_SHIM_UNK : TAG_SHIM_LEN;
                if (n_pos == 16'd2) n_len = {1'b0, i_data, 8'd0};
                if (n_pos == 16'd3) begin
                    n_len = {1'b0, n_len[15:8], i_data} + 17'd4;
                    n_phase = PH_HDR;
                end
            end
            PH_HDR: begin
                tag = (r < 16'd4) ? TAG_HDR_UNK : (r < 16'd8) ? TAG_DSTID :
                      (r < 16'd12) ? TAG_SRCID : (r < 16'd14) ? TAG_DSTTYPE : TAG_SRCTYPE;
                if (r == 16'd12) n_thigh = i_data;
                if (r == 16'd13) n_type = {n_thigh, i_data};
                if (r == 16'd15) begin
                    if (n_type == TYPE_UC) n_phase = PH_UC;
                    else if (n_type == TYPE_BC) n_phase = PH_BC;
                    else if (n_type == TYPE_C0C || n_type == TYPE_C1E || n_type == TYPE_T22)
                        n_phase = PH_CTRL;
                    else n_phase = PH_UNKNOWN;
                end
            end
            PH_UC: begin
                tag = TAG_DATA_UNK;
                if (r == 16'd17) n_phase = PH_PAYLOAD;
            end
            PH_BC: begin
                tag = (r < 16'd18) ? TAG_VLAN : (r < 16'd22) ? TAG_SEQNO : TAG_DATA_UNK;
                if (r == 16'd25) n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: tag = (pos17 < n_len) ? TAG_PAYLOAD : TAG_TRAIL;
            PH_CTRL: begin
                if (r < 16'd48) begin
                    tag = TAG_ZERO;
                    if (r == 16'd47 && n_type == TYPE_C1E) n_phase = PH_1E;
                end else if (n_type == TYPE_T22) begin
                    tag = TAG_MSG22;
                    if (r == 16'd49) n_phase = PH_TLV_TYPE;
                end else if (r < 16'd51) begin
                    tag = TAG_PRE;
                end else if (r == 16'd51) begin
                    tag = TAG_HDRLEN;
                    n_hext = i_data;
                end else if (r < 16'd56) begin
                    tag = TAG_MSGTYPE;
                    n_msg = {n_msg[23:0], i_data};
                    if (r == 16'd55) begin
                        if (n_msg == MSG_CSNP) n_esz = 4'd12;
                        else if (n_msg == MSG_LSP) n_esz = 4'd8;
                        else if (n_msg == MSG_PSNP) n_esz = 4'd4;
                        else n_esz = 4'd0;
                    end
                end else begin
                    tag = TAG_SENDER;
                    if (r == 16'd59) begin
                        if (n_hext > 8'd12) begin
                            n_rem = {1'b0, n_hext - 8'd12};
                            n_phase = PH_EXTRA;
                        end else begin
                            n_phase = PH_TLV_TYPE;
                        end
                    end
                end
            end
            PH_EXTRA: begin
                tag = TAG_EXTRA;
                n_rem = n_rem - 9'd1;
                if (n_rem == 9'd0) n_phase = PH_TLV_TYPE;
            end
            PH_TLV_TYPE: begin
                if (pos17 + 17'd2 < n_len) begin
                    tag = TAG_TLV_TYPE;
                    n_kind = i_data;
                    n_phase = PH_TLV_LEN;
                end else begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_TLV_LEN: begin
                if (n_type == TYPE_C0C && n_kind == TLV_ARRAY_KIND && i_data == ARRAY_MARK) begin
                    tag = TAG_ARRAY;
                    n_phase = PH_TLV_LEN2;
                end else begin
                    do_take = 1'b1;
                end
            end
            PH_TLV_LEN2: do_take = 1'b1;
            PH_VALUE: begin
                if (split) begin
                    tag = TAG_ELEMENT;
                    el = (n_ecnt == 4'd0);
                    n_ecnt = n_ecnt + 4'd1;
                    if (n_ecnt >= n_esz) n_ecnt = 4'd0;
                end else begin
                    tag = TAG_VALUE;
                end
                n_rem = n_rem - 9'd1;
                if (n_rem == 9'd0) n_phase = PH_TLV_TYPE;
            end
            PH_1E: tag = (pos17 < n_len) ? TAG_1E_UNK : TAG_TRAIL;
            PH_UNKNOWN: tag = (pos17 < n_len) ?
                ((n_via == SRC_DATA) ? TAG_DATA_UNK : TAG_CTRL_UNK) : TAG_TRAIL;
            default: tag = TAG_TRAIL;
        endcase
        if (do_take) begin
            tag = TAG_TLV_LEN;
            if (pos17 + 17'd1 + {9'd0, dlen} > n_len) begin
                n_stop = 1'b1;
                n_phase = PH_TRAIL;
            end else begin
                n_rem = split ? round_elem(dlen, n_esz) : {1'b0, dlen};
                n_ecnt = 4'd0;
                n_phase = (n_rem != 9'd0) ? PH_VALUE : PH_TLV_TYPE;
            end
        end
        o_res.tag = tag;
        o_res.frame_type = n_type;
        o_res.el_start = el;
        o_res.truncated = n_stop;
        o_res.frame_end = i_last;
        if (n_pos != 16'hffff) n_pos = n_pos + 16'd1;
        if (i_last) n_phase = PH_START;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_pos <= '0; r_len <= '0; r_type <= '0;
            r_thigh <= '0; r_hext <= '0; r_msg <= '0; r_esz <= '0; r_kind <= '0;
            r_rem <= '0; r_ecnt <= '0; r_stop <= 1'b0; r_via <= '0;
        end else if (i_en) begin
            r_phase <= n_phase; r_pos <= n_pos; r_len <= n_len; r_type <= n_type;
            r_thigh <= n_thigh; r_hext <= n_hext; r_msg <= n_msg; r_esz <= n_esz;
            r_kind <= n_kind; r_rem <= n_rem; r_ecnt <= n_ecnt; r_stop <= n_stop;
            r_via <= n_via;
        end
    end

endmodule
